>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
// Included by the top level; the checks drop out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> hw/rtl/qkbd_pkg.sv
// Types, codes and widths for the quadrature knob and button decoder.
// No dependencies; imported by qkbd_core and the top level.
package qkbd_pkg;

  localparam int unsigned TimeBits = 32;
  localparam int unsigned LimBits  = 16;
  localparam int unsigned IdxBits  = 3;

  typedef enum logic [2:0] {
    WalkIdle = 3'd0,
    WalkCw1  = 3'd1,
    WalkCw2  = 3'd2,
    WalkCw3  = 3'd3,
    WalkAcw1 = 3'd4,
    WalkAcw2 = 3'd5,
    WalkAcw3 = 3'd6
  } qkbd_walk_e;

  typedef enum logic [3:0] {
    EvNone    = 4'd0,
    EvDown    = 4'd1,
    EvUp      = 4'd2,
    EvDouble  = 4'd3,
    EvHold    = 4'd4,
    EvCwSlow  = 4'd5,
    EvCwMed   = 4'd6,
    EvCwFast  = 4'd7,
    EvAcwSlow = 4'd8,
    EvAcwMed  = 4'd9,
    EvAcwFast = 4'd10
  } qkbd_event_e;

  typedef enum logic [IdxBits-1:0] {
    RegEnable   = 3'd0,
    RegDebounce = 3'd1,
    RegHold     = 3'd2,
    RegDouble   = 3'd3,
    RegMedium   = 3'd4,
    RegFast     = 3'd5
  } qkbd_reg_e;

  typedef struct packed {
    logic [1:0]         enable_mode;
    logic [LimBits-1:0] debounce_ms;
    logic [LimBits-1:0] hold_ms;
    logic [LimBits-1:0] double_click_ms;
    logic [LimBits-1:0] medium_speed_ms;
    logic [LimBits-1:0] fast_speed_ms;
  } qkbd_cfg_t;

  typedef struct packed {
    logic                pin_a;
    logic                pin_b;
    logic                pin_btn;
    logic [TimeBits-1:0] now_ms;
  } qkbd_poll_t;

endpackage

>>> hw/rtl/qkbd_core.sv
// Per-poll decode: button debounce/click/hold timers and the quadrature walker.
// Depends on qkbd_pkg; holds all decoder state and updates it when step_i is high.
module qkbd_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  qkbd_pkg::qkbd_poll_t poll_i,
  input  qkbd_pkg::qkbd_cfg_t  cfg_i,
  output logic [3:0]         event_o
);
  import qkbd_pkg::*;

  logic                last_a_q, last_a_d, last_b_q, last_b_d, last_btn_q, last_btn_d;
  qkbd_walk_e          walk_q, walk_d;
  logic [TimeBits-1:0] deb_start_q, deb_start_d, hold_start_q, hold_start_d;
  logic [TimeBits-1:0] dc_start_q, dc_start_d, det_start_q, det_start_d;

  logic [TimeBits-1:0] deb_el, hold_el, dc_el, det_el;
  logic                deb_exp, hold_exp, dc_exp;
  logic                btn_en, enc_en, edge_ok, hold_ev;
  logic                a, b, lo, hi, ab, ba, moved, detent;
  logic [3:0]          ev, det_base;
  logic [1:0]          speed;

  assign a       = poll_i.pin_a;
  assign b       = poll_i.pin_b;
  assign lo      = !a && !b;
  assign hi      = a && b;
  assign ab      = a && !b;
  assign ba      = !a && b;
  assign btn_en  = cfg_i.enable_mode[0];
  assign enc_en  = cfg_i.enable_mode[1];

  assign deb_el  = poll_i.now_ms - deb_start_q;
  assign hold_el = poll_i.now_ms - hold_start_q;
  assign dc_el   = poll_i.now_ms - dc_start_q;
  assign det_el  = poll_i.now_ms - det_start_q;

  assign deb_exp  = deb_el  >= TimeBits'(cfg_i.debounce_ms);
  assign hold_exp = hold_el >= TimeBits'(cfg_i.hold_ms);
  assign dc_exp   = dc_el   >= TimeBits'(cfg_i.double_click_ms);

  assign edge_ok = btn_en && (poll_i.pin_btn != last_btn_q) && deb_exp;
  assign hold_ev = btn_en && !edge_ok && !poll_i.pin_btn && hold_exp;
  assign moved   = (a != last_a_q) || (b != last_b_q);

  always_comb begin
    if (det_el < TimeBits'(cfg_i.fast_speed_ms)) begin
      speed = 2'd2;
    end else if (det_el < TimeBits'(cfg_i.medium_speed_ms)) begin
      speed = 2'd1;
    end else begin
      speed = 2'd0;
    end
  end

  always_comb begin
    last_a_d    = last_a_q;
    last_b_d    = last_b_q;
    last_btn_d  = last_btn_q;
    walk_d      = walk_q;
    deb_start_d = deb_start_q;
    hold_start_d = hold_start_q;
    dc_start_d  = dc_start_q;
    det_start_d = det_start_q;
    ev          = EvNone;
    detent      = 1'b0;
    det_base    = EvCwSlow;

    if (btn_en) begin
      last_btn_d = poll_i.pin_btn;
    end

    if (edge_ok) begin
      deb_start_d = poll_i.now_ms;
      if (poll_i.pin_btn) begin
        if (dc_exp) begin
          dc_start_d = poll_i.now_ms;
          ev         = EvUp;
        end else begin
          ev = EvDouble;
        end
      end else begin
        hold_start_d = poll_i.now_ms;
        ev           = EvDown;
      end
    end else if (hold_ev) begin
      hold_start_d = poll_i.now_ms;
      ev           = EvHold;
    end else if (enc_en) begin
      last_a_d = a;
      last_b_d = b;
      if (moved) begin
        unique case (walk_q)
          WalkCw1:  walk_d = lo ? WalkCw2 : WalkIdle;
          WalkCw2:  walk_d = ba ? WalkCw3 : (ab ? WalkCw1 : WalkIdle);
          WalkCw3: begin
            detent   = hi;
            det_base = EvCwSlow;
            walk_d   = lo ? WalkCw2 : WalkIdle;
          end
          WalkAcw1: walk_d = lo ? WalkAcw2 : WalkIdle;
          WalkAcw2: walk_d = ab ? WalkAcw3 : (ba ? WalkAcw1 : WalkIdle);
          WalkAcw3: begin
            detent   = hi;
            det_base = EvAcwSlow;
            walk_d   = lo ? WalkAcw2 : WalkIdle;
          end
          default:  walk_d = ba ? WalkAcw1 : (ab ? WalkCw1 : WalkIdle);
        endcase
        if (detent) begin
          det_start_d = poll_i.now_ms;
          ev          = qkbd_event_e'(det_base + {2'b00, speed});
        end
      end
    end
  end

  assign event_o = ev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_a_q     <= 1'b0;
      last_b_q     <= 1'b0;
      last_btn_q   <= 1'b0;
      walk_q       <= WalkIdle;
      deb_start_q  <= '0;
      hold_start_q <= '0;
      dc_start_q   <= '0;
      det_start_q  <= '0;
    end else if (step_i) begin
      last_a_q     <= last_a_d;
      last_b_q     <= last_b_d;
      last_btn_q   <= last_btn_d;
      walk_q       <= walk_d;
      deb_start_q  <= deb_start_d;
      hold_start_q <= hold_start_d;
      dc_start_q   <= dc_start_d;
      det_start_q  <= det_start_d;
    end
  end

endmodule

>>> hw/rtl/quadrature_knob_and_button_decoder.sv
// Quadrature knob and push-button decoder. One result beat (event_code) per
// input beat, with 0 meaning no event. An accepted beat is held in an input
// register; once the output register is free or being read, the decode logic
// updates the timers and walker and the event is loaded into the output
// register. A beat is accepted every cycle while the output side keeps taking beats.
// Depends on qkbd_pkg, qkbd_core and assert_macros.svh.
`include "assert_macros.svh"
module quadrature_knob_and_button_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [qkbd_pkg::IdxBits-1:0] cfg_idx_i,
  input  logic [qkbd_pkg::LimBits-1:0] cfg_data_i,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // pin_a, pin_b, pin_btn, now_ms[31:0], pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // event_code[3:0], pad
);
  import qkbd_pkg::*;

  qkbd_cfg_t  cfg_q;
  qkbd_poll_t poll_q;
  logic       in_valid_q, out_valid_q, out_free, advance;
  logic [3:0] out_code_q, core_ev;

  assign out_free = !out_valid_q || m_tready;
  assign advance  = in_valid_q && out_free;
  assign s_tready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable_mode     <= 2'd3;
      cfg_q.debounce_ms     <= LimBits'(50);
      cfg_q.hold_ms         <= LimBits'(1000);
      cfg_q.double_click_ms <= LimBits'(300);
      cfg_q.medium_speed_ms <= LimBits'(200);
      cfg_q.fast_speed_ms   <= LimBits'(50);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegEnable:   cfg_q.enable_mode     <= cfg_data_i[1:0];
        RegDebounce: cfg_q.debounce_ms     <= cfg_data_i;
        RegHold:     cfg_q.hold_ms         <= cfg_data_i;
        RegDouble:   cfg_q.double_click_ms <= cfg_data_i;
        RegMedium:   cfg_q.medium_speed_ms <= cfg_data_i;
        RegFast:     cfg_q.fast_speed_ms   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid_q <= s_tvalid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tvalid && s_tready) begin
      poll_q.pin_a   <= s_tdata[0];
      poll_q.pin_b   <= s_tdata[1];
      poll_q.pin_btn <= s_tdata[2];
      poll_q.now_ms  <= s_tdata[34:3];
    end
    if (advance) begin
      out_code_q <= core_ev;
    end
  end

  qkbd_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .poll_i  (poll_q),
    .cfg_i   (cfg_q),
    .event_o (core_ev)
  );

  assign m_tvalid = out_valid_q;
  assign m_tdata  = {4'b0000, out_code_q};

  `ASSERT_CLK(a_adv_fills_out, clk_i, rst_ni, advance |=> m_tvalid, "beat lost in output stage")
  `ASSERT_CLK(a_stall_cause, clk_i, rst_ni,
              !s_tready |-> (in_valid_q && m_tvalid && !m_tready), "input stalled without cause")
  `ASSERT_CLK(a_code_range, clk_i, rst_ni,
              m_tvalid |-> (m_tdata[3:0] <= EvAcwFast), "event code out of range")

endmodule
